>>> rtl/soft_threshold_with_truncation_macros.svh
// ----------------------------------------------------------------------------
// Soft threshold with truncation: assertion macros
// Shared concurrent assertion shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef SOFT_THRESHOLD_WITH_TRUNCATION_MACROS_SVH
`define SOFT_THRESHOLD_WITH_TRUNCATION_MACROS_SVH

// same-cycle implication
`define STT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stt assertion failed");

// next-cycle implication
`define STT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stt assertion failed");

`endif

>>> rtl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Types, widths and constants for the soft threshold with truncation block.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int VECTOR_LEN_DEF = 64;

    localparam int X_W    = 32;
    localparam int W_W    = 32;
    localparam int MAG_W  = 32;
    localparam int DF_W   = 25;
    localparam int NORM_W = 38;
    localparam int IDX_W  = 6;
    localparam int CNTO_W = 7;
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 32;
    localparam int LIM_W  = DF_W + NORM_W;
    localparam int SPLIT  = NORM_W / 2;

    localparam logic [CFG_IW-1:0] CFG_PENALTY   = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_STEP      = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_WEIGHTED  = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_TRUNCATE  = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_DROP_FRAC = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_TOLERANCE = 3'd5;

    localparam logic [31:0]     PENALTY_RST   = 32'd65536;
    localparam logic [31:0]     STEP_RST      = 32'd65536;
    localparam logic [DF_W-1:0] DROP_FRAC_RST = 25'd1678;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_WRITE,
        ST_LIMIT,
        ST_LIMSUM,
        ST_CNT,
        ST_TR_RDK,
        ST_TR_LDK,
        ST_TR_SW,
        ST_TR_DEC,
        ST_EM_RD,
        ST_EM_LD,
        ST_EM_HOLD
    } stt_state_t;

    function automatic logic [31:0] sat_q16(input logic [63:0] prod);
        logic [31:0] r;
        r = (prod[63:48] != 16'd0) ? 32'hFFFF_FFFF : prod[47:16];
        return r;
    endfunction

endpackage

>>> rtl/stt_if.sv
// ----------------------------------------------------------------------------
// stt_in_if / stt_out_if
// Valid/ready channels for element and result transactions.
// ----------------------------------------------------------------------------
interface stt_in_if;
    import stt_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [X_W-1:0]   x_value;
    logic        [W_W-1:0]   weight;
    logic                    last;
    modport source (output valid, x_value, weight, last, input ready);
    modport sink   (input valid, x_value, weight, last, output ready);
endinterface

interface stt_out_if;
    import stt_pkg::*;
    logic                    valid;
    logic                    ready;
    logic        [IDX_W-1:0]  elem_index;
    logic signed [X_W-1:0]    y_value;
    logic                     last_out;
    logic        [CNTO_W-1:0] nonzero_count;
    logic        [CNTO_W-1:0] kept_count;
    logic                     overflow;
    modport source (output valid, elem_index, y_value, last_out, nonzero_count,
                    kept_count, overflow, input ready);
    modport sink   (input valid, elem_index, y_value, last_out, nonzero_count,
                    kept_count, overflow, output ready);
endinterface

>>> rtl/stt_ram.sv
// ----------------------------------------------------------------------------
// stt_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module stt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> rtl/soft_threshold_with_truncation.sv
// ----------------------------------------------------------------------------
// soft_threshold_with_truncation
// Each element is loaded by a registered 32x32 threshold multiply, a second
// registered multiply by the weight in weighted mode, then the write of sign
// and shrunk magnitude into the element RAM. On a last element the block
// computes the L1 drop limit, counts nonzeros in one RAM sweep, then, in
// truncation mode, ranks every entry by a full sweep of the single-port RAM,
// and emits the results, holding each through any output stall. No element
// is taken from the load until the last result is delivered. Elements beyond
// VECTOR_LEN are dropped and flagged as overflow.
// ----------------------------------------------------------------------------
module soft_threshold_with_truncation #(
    parameter int VECTOR_LEN = stt_pkg::VECTOR_LEN_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    stt_in_if.sink                      in_ch,
    stt_out_if.source                   out_ch,
    input  logic                        cfg_we,
    input  logic [stt_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [stt_pkg::CFG_DW-1:0]  cfg_data
);
    import stt_pkg::*;

    localparam int AW = $clog2(VECTOR_LEN);
    localparam int CW = $clog2(VECTOR_LEN + 1);
    localparam logic [CW-1:0] CAP = CW'(VECTOR_LEN);

    // configuration
    logic [31:0]     penalty_reg, step_reg, tol_reg;
    logic            weighted_reg, trunc_reg;
    logic [DF_W-1:0] df_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            penalty_reg  <= PENALTY_RST;
            step_reg     <= STEP_RST;
            weighted_reg <= 1'b0;
            trunc_reg    <= 1'b0;
            df_reg       <= DROP_FRAC_RST;
            tol_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PENALTY:   penalty_reg  <= cfg_data;
                CFG_STEP:      step_reg     <= cfg_data;
                CFG_WEIGHTED:  weighted_reg <= cfg_data[0];
                CFG_TRUNCATE:  trunc_reg    <= cfg_data[0];
                CFG_DROP_FRAC: df_reg       <= cfg_data[DF_W-1:0];
                CFG_TOLERANCE: tol_reg      <= cfg_data;
                default:       ;
            endcase
        end
    end

    stt_state_t state_reg, state_next;

    logic [CW-1:0]     count_reg, count_next;
    logic [NORM_W-1:0] norm_reg, norm_next;
    logic              ovf_reg, ovf_next;
    logic [CW-1:0]     nnz_reg, nnz_next;
    logic [CW-1:0]     drop_reg, drop_next;
    logic [CW-1:0]     j_reg, j_next;
    logic [CW-1:0]     k_reg, k_next;
    logic              pv_reg, pv_next;
    logic [CW-1:0]     pj_reg, pj_next;
    logic [NORM_W-1:0] sum_reg, sum_next;
    logic [MAG_W-1:0]  mk_reg, mk_next;
    logic [LIM_W-1:0]  limit_reg, limit_next;
    logic [LIM_W-1:0]  plo_reg, plo_next, phi_reg, phi_next;

    logic [X_W-1:0]    x_reg, x_next;
    logic [W_W-1:0]    w_reg, w_next;
    logic              last_reg, last_next;
    logic [63:0]       prod_reg, prod_next;

    logic [IDX_W-1:0]  o_idx_reg, o_idx_next;
    logic [X_W-1:0]    o_y_reg, o_y_next;
    logic              o_last_reg, o_last_next;

    // RAM ports
    logic              ram_we, drop_we, drop_wdata, drop_rdata;
    logic [AW-1:0]     ram_addr;
    logic [MAG_W:0]    ram_wdata, ram_rdata;

    stt_ram #(.WIDTH(MAG_W + 1), .DEPTH(VECTOR_LEN)) u_elem_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    stt_ram #(.WIDTH(1), .DEPTH(VECTOR_LEN)) u_drop_ram (
        .clk   (clk),
        .we    (drop_we),
        .addr  (ram_addr),
        .wdata (drop_wdata),
        .rdata (drop_rdata)
    );

    logic              in_acc;
    logic [MAG_W-1:0]  abs_x, thr, shrunk, rd_mag, em_mag;
    logic              rd_nz, sweep_done, counted, zero_k;
    logic [LIM_W-1:0]  scaled_sum;

    assign in_acc     = in_ch.valid && in_ch.ready;
    assign abs_x      = x_reg[X_W-1] ? (~x_reg + 32'd1) : x_reg;
    assign thr        = weighted_reg ? sat_q16(prod_reg) : prod_reg[31:0];
    assign shrunk     = (abs_x > thr) ? (abs_x - thr) : '0;
    assign rd_mag     = ram_rdata[MAG_W-1:0];
    assign rd_nz      = rd_mag > tol_reg;
    assign sweep_done = (j_reg == count_reg) && !pv_reg;
    assign counted    = (rd_mag < mk_reg) || ((rd_mag == mk_reg) && (pj_reg <= k_reg));
    assign scaled_sum = LIM_W'({sum_reg, 24'd0});
    assign zero_k     = (mk_reg > tol_reg) && (scaled_sum <= limit_reg);
    assign em_mag     = (trunc_reg && drop_rdata) ? '0 : rd_mag;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    priority if (count_reg != CAP)
                        state_next = ST_MUL1;
                    else if (in_ch.last)
                        state_next = ST_LIMIT;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_MUL1:    state_next = ST_MUL2;
            ST_MUL2:    state_next = ST_WRITE;
            ST_WRITE:   state_next = last_reg ? ST_LIMIT : ST_IDLE;
            ST_LIMIT:   state_next = ST_LIMSUM;
            ST_LIMSUM:  state_next = ST_CNT;
            ST_CNT:
            begin
                if (sweep_done)
                    state_next = trunc_reg ? ST_TR_RDK : ST_EM_RD;
            end
            ST_TR_RDK:  state_next = ST_TR_LDK;
            ST_TR_LDK:  state_next = ST_TR_SW;
            ST_TR_SW:   state_next = sweep_done ? ST_TR_DEC : ST_TR_SW;
            ST_TR_DEC:
            begin
                state_next = (CW'(k_reg + 1'b1) == count_reg) ? ST_EM_RD : ST_TR_RDK;
            end
            ST_EM_RD:   state_next = ST_EM_LD;
            ST_EM_LD:   state_next = ST_EM_HOLD;
            ST_EM_HOLD:
            begin
                if (out_ch.ready)
                    state_next = o_last_reg ? ST_IDLE : ST_EM_RD;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // datapath and control
    always_comb
    begin
        count_next  = count_reg;
        norm_next   = norm_reg;
        ovf_next    = ovf_reg;
        nnz_next    = nnz_reg;
        drop_next   = drop_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        pv_next     = 1'b0;
        pj_next     = j_reg;
        sum_next    = sum_reg;
        mk_next     = mk_reg;
        limit_next  = limit_reg;
        plo_next    = plo_reg;
        phi_next    = phi_reg;
        x_next      = x_reg;
        w_next      = w_reg;
        last_next   = last_reg;
        prod_next   = prod_reg;
        o_idx_next  = o_idx_reg;
        o_y_next    = o_y_reg;
        o_last_next = o_last_reg;
        ram_we      = 1'b0;
        drop_we     = 1'b0;
        drop_wdata  = zero_k;
        ram_addr    = count_reg[AW-1:0];
        ram_wdata   = {x_reg[X_W-1], shrunk};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    x_next    = in_ch.x_value;
                    w_next    = in_ch.weight;
                    last_next = in_ch.last;
                    if (count_reg == CAP)
                        ovf_next = 1'b1;
                end
            end
            ST_MUL1:
            begin
                prod_next = {32'd0, step_reg} * {32'd0, penalty_reg};
            end
            ST_MUL2:
            begin
                prod_next = weighted_reg ? ({32'd0, sat_q16(prod_reg)} * {32'd0, w_reg})
                                         : {32'd0, sat_q16(prod_reg)};
            end
            ST_WRITE:
            begin
                ram_we     = 1'b1;
                count_next = CW'(count_reg + 1'b1);
                norm_next  = norm_reg + NORM_W'(shrunk);
            end
            ST_LIMIT:
            begin
                plo_next = LIM_W'({{(NORM_W-SPLIT){1'b0}}, df_reg} *
                                  {{DF_W{1'b0}}, norm_reg[SPLIT-1:0]});
                phi_next = LIM_W'({{SPLIT{1'b0}}, df_reg} *
                                  {{DF_W{1'b0}}, norm_reg[NORM_W-1:SPLIT]});
            end
            ST_LIMSUM:
            begin
                limit_next = plo_reg + (phi_reg << SPLIT);
                j_next     = '0;
                nnz_next   = '0;
            end
            ST_CNT:
            begin
                ram_addr = j_reg[AW-1:0];
                if (j_reg != count_reg)
                begin
                    pv_next = 1'b1;
                    j_next  = CW'(j_reg + 1'b1);
                end
                if (pv_reg && rd_nz)
                    nnz_next = CW'(nnz_reg + 1'b1);
                k_next     = '0;
                drop_next  = '0;
                o_idx_next = '0;
            end
            ST_TR_RDK:
            begin
                ram_addr = k_reg[AW-1:0];
            end
            ST_TR_LDK:
            begin
                mk_next  = rd_mag;
                j_next   = '0;
                sum_next = '0;
            end
            ST_TR_SW:
            begin
                ram_addr = j_reg[AW-1:0];
                if (j_reg != count_reg)
                begin
                    pv_next = 1'b1;
                    j_next  = CW'(j_reg + 1'b1);
                end
                if (pv_reg && rd_nz && counted)
                    sum_next = sum_reg + NORM_W'(rd_mag);
            end
            ST_TR_DEC:
            begin
                ram_addr = k_reg[AW-1:0];
                drop_we  = 1'b1;
                if (zero_k)
                    drop_next = CW'(drop_reg + 1'b1);
                k_next = CW'(k_reg + 1'b1);
            end
            ST_EM_RD:
            begin
                ram_addr = o_idx_reg[AW-1:0];
            end
            ST_EM_LD:
            begin
                o_y_next    = ram_rdata[MAG_W] ? (~em_mag + 32'd1) : em_mag;
                o_last_next = (CW'(o_idx_reg) + 1'b1) == count_reg;
            end
            ST_EM_HOLD:
            begin
                if (out_ch.ready)
                begin
                    o_idx_next = IDX_W'(o_idx_reg + 1'b1);
                    if (o_last_reg)
                    begin
                        count_next = '0;
                        norm_next  = '0;
                        ovf_next   = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            norm_reg  <= '0;
            ovf_reg   <= 1'b0;
            pv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            norm_reg  <= norm_next;
            ovf_reg   <= ovf_next;
            pv_reg    <= pv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nnz_reg    <= nnz_next;
        drop_reg   <= drop_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        pj_reg     <= pj_next;
        sum_reg    <= sum_next;
        mk_reg     <= mk_next;
        limit_reg  <= limit_next;
        plo_reg    <= plo_next;
        phi_reg    <= phi_next;
        x_reg      <= x_next;
        w_reg      <= w_next;
        last_reg   <= last_next;
        prod_reg   <= prod_next;
        o_idx_reg  <= o_idx_next;
        o_y_reg    <= o_y_next;
        o_last_reg <= o_last_next;
    end

    assign in_ch.ready          = (state_reg == ST_IDLE);
    assign out_ch.valid         = (state_reg == ST_EM_HOLD);
    assign out_ch.elem_index    = o_idx_reg;
    assign out_ch.y_value       = o_y_reg;
    assign out_ch.last_out      = o_last_reg;
    assign out_ch.nonzero_count = CNTO_W'(nnz_reg);
    assign out_ch.kept_count    = CNTO_W'(nnz_reg - drop_reg);
    assign out_ch.overflow      = ovf_reg;

endmodule

>>> rtl/stt_checker.sv
// ----------------------------------------------------------------------------
// stt_checker
// Port-level assertions for soft_threshold_with_truncation, bound to the top.
// ----------------------------------------------------------------------------
`include "soft_threshold_with_truncation_macros.svh"

module stt_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [stt_pkg::X_W-1:0]     y_value,
    input logic [stt_pkg::IDX_W-1:0]   elem_index,
    input logic [stt_pkg::CNTO_W-1:0]  nonzero_count,
    input logic [stt_pkg::CNTO_W-1:0]  kept_count
);
    import stt_pkg::*;

    `STT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(y_value) && $stable(elem_index))
    `STT_ASSERT_SAME(a_kept_le_nnz, clk, rst_n, out_valid, kept_count <= nonzero_count)
    `STT_ASSERT_NEXT(a_no_out_after_in, clk, rst_n, in_valid && in_ready, !out_valid)
    `STT_ASSERT_SAME(a_no_in_while_out, clk, rst_n, out_valid, !in_ready)

endmodule

bind soft_threshold_with_truncation stt_checker u_stt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .y_value       (out_ch.y_value),
    .elem_index    (out_ch.elem_index),
    .nonzero_count (out_ch.nonzero_count),
    .kept_count    (out_ch.kept_count)
);

>>> tb/sv/soft_threshold_with_truncation_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// soft_threshold_with_truncation_test
// Loads vectors through the element channel with random gaps and back
// pressure, predicts each result with a behavioral threshold and truncation
// model, and compares every result transaction field by field.
// ----------------------------------------------------------------------------
module soft_threshold_with_truncation_test;
    import stt_pkg::*;

    localparam logic [CFG_IW-1:0] CFG_UNUSED = 3'd6;

    typedef struct packed {
        logic [IDX_W-1:0]  elem_index;
        logic [X_W-1:0]    y_value;
        logic              last_out;
        logic [CNTO_W-1:0] nonzero_count;
        logic [CNTO_W-1:0] kept_count;
        logic              overflow;
    } result_t;

    typedef struct {
        logic [X_W-1:0] x;
        logic [W_W-1:0] w;
        logic           lst;
        bit             has_exp;
        logic [X_W-1:0] exp_y;
    } row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IW-1:0] cfg_index;
    logic [CFG_DW-1:0] cfg_data;

    stt_in_if  in_ch();
    stt_out_if out_ch();

    soft_threshold_with_truncation u_top (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // shadow registers and vector state
    logic [31:0] m_penalty, m_step, m_tol;
    logic        m_weighted, m_truncate;
    logic [24:0] m_drop;
    logic [31:0] mag_q[$];
    logic        sgn_q[$];
    logic [37:0] l1_norm;
    logic        ovf;

    result_t expected_results[$];
    int errors = 0;
    int mismatches = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("soft_threshold_with_truncation_test NOT OK");
        $finish;
    end

    function automatic logic [31:0] shrunk_magnitude(logic [31:0] xb, logic [31:0] w);
        logic [63:0] mag;
        logic [63:0] thr;
        mag = xb[31] ? {32'd0, (~xb) + 32'd1} : {32'd0, xb};
        thr = ({32'd0, m_step} * {32'd0, m_penalty}) >> 16;
        if (thr > 64'hFFFF_FFFF) thr = 64'hFFFF_FFFF;
        if (m_weighted)
        begin
            thr = (thr * {32'd0, w}) >> 16;
            if (thr > 64'hFFFF_FFFF) thr = 64'hFFFF_FFFF;
        end
        return (mag > thr) ? 32'(mag - thr) : 32'd0;
    endfunction

    task automatic load_element(logic [31:0] xb, logic [31:0] w, logic lst);
        logic [31:0] d;
        int n, nnz, dropped, r;
        int order[64];
        bit zeroed[64];
        logic [95:0] run_sum;
        logic [95:0] limit;
        result_t res;
        if (mag_q.size() < 64)
        begin
            d = shrunk_magnitude(xb, w);
            mag_q.insert(mag_q.size(), d);
            sgn_q.insert(sgn_q.size(), xb[31]);
            l1_norm += d;
        end
        else
            ovf = 1'b1;
        if (!lst) return;
        n = mag_q.size();
        nnz = 0;
        dropped = 0;
        for (int i = 0; i < n; i++)
        begin
            zeroed[i] = 0;
            if (mag_q[i] > m_tol) nnz++;
        end
        if (m_truncate)
        begin
            for (int i = 0; i < n; i++)
            begin
                if (mag_q[i] <= m_tol) continue;
                r = 0;
                for (int j = 0; j < n; j++)
                    if (mag_q[j] > m_tol && (mag_q[j] < mag_q[i] ||
                        (mag_q[j] == mag_q[i] && j < i))) r++;
                order[r] = i;
            end
            run_sum = 0;
            limit = 96'(m_drop) * 96'(l1_norm);
            for (int j = 0; j < nnz; j++)
            begin
                run_sum += mag_q[order[j]];
                if ((run_sum << 24) > limit) break;
                zeroed[order[j]] = 1;
                dropped++;
            end
        end
        for (int i = 0; i < n; i++)
        begin
            d = zeroed[i] ? 32'd0 : mag_q[i];
            res.elem_index = IDX_W'(i);
            res.y_value = sgn_q[i] ? -d : d;
            res.last_out = (i == n - 1);
            res.nonzero_count = CNTO_W'(nnz);
            res.kept_count = CNTO_W'(nnz - dropped);
            res.overflow = ovf;
            expected_results.insert(expected_results.size(), res);
        end
        mag_q.delete();
        sgn_q.delete();
        l1_norm = 0;
        ovf = 0;
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_PENALTY:   m_penalty = val;
            CFG_STEP:      m_step = val;
            CFG_WEIGHTED:  m_weighted = val[0];
            CFG_TRUNCATE:  m_truncate = val[0];
            CFG_DROP_FRAC: m_drop = val[24:0];
            CFG_TOLERANCE: m_tol = val;
            default: ;
        endcase
    endtask

    task automatic send_element(logic [31:0] xb, logic [31:0] w, logic lst);
        int gap;
        gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.x_value <= xb;
        in_ch.weight <= w;
        in_ch.last <= lst;
        do @(posedge clk); while (!in_ch.ready);
        load_element(xb, w, lst);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // result checker with random stall per transaction
    initial
    begin
        result_t got, exp;
        int stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, 11);
            if (stall != 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            got = '{out_ch.elem_index, out_ch.y_value, out_ch.last_out,
                    out_ch.nonzero_count, out_ch.kept_count, out_ch.overflow};
            if (expected_results.size() == 0)
            begin
                errors++;
                if (mismatches++ < 10)
                    $display("unexpected transaction %p", got);
            end
            else
            begin
                exp = expected_results.pop_front();
                if (got !== exp)
                begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("mismatch: expected %p actual %p", exp, got);
                end
            end
        end
    end

    row_t dir_rows[$];

    initial
    begin
        int len;
        logic [31:0] xb;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.x_value = '0;
        in_ch.weight = '0;
        in_ch.last = 1'b0;
        m_penalty = PENALTY_RST;
        m_step = STEP_RST;
        m_weighted = 0;
        m_truncate = 0;
        m_drop = DROP_FRAC_RST;
        m_tol = 0;
        l1_norm = 0;
        ovf = 0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset threshold is 1.0
        dir_rows = '{
            '{32'h0001_8000, 32'h0, 1'b0, 1'b1, 32'h0000_8000},
            '{32'hFFFE_8000, 32'h0, 1'b0, 1'b1, 32'hFFFF_8000},
            '{32'h0000_8000, 32'h0, 1'b0, 1'b1, 32'h0},
            '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'h7FFE_FFFF},
            '{32'h8000_0000, 32'h0, 1'b0, 1'b1, 32'h8001_0000},
            '{32'h0, 32'h0, 1'b1, 1'b1, 32'h0}
        };
        foreach (dir_rows[i])
        begin
            send_element(dir_rows[i].x, dir_rows[i].w, dir_rows[i].lst);
            if (dir_rows[i].lst)
                foreach (expected_results[k])
                    if (dir_rows[k].has_exp)
                        expected_results[k].y_value = dir_rows[k].exp_y;
        end
        drain_results();

        // weighted, truncation, extreme drop
        write_reg(CFG_WEIGHTED, 32'd1);
        write_reg(CFG_TRUNCATE, 32'd1);
        write_reg(CFG_DROP_FRAC, 32'd16777216);
        write_reg(CFG_TOLERANCE, 32'h0000_1000);
        write_reg(CFG_PENALTY, 32'hFFFF_FFFF);
        write_reg(CFG_STEP, 32'h0000_0001);
        send_element(32'h0010_0000, 32'h0, 1'b0);
        send_element(32'hFFF0_0000, 32'hFFFF_FFFF, 1'b0);
        send_element(32'h0010_0000, 32'h0001_0000, 1'b0);
        send_element(32'h0000_0800, 32'h0, 1'b1);
        drain_results();

        // overflow: 66 elements, last beyond capacity
        write_reg(CFG_DROP_FRAC, 32'd0);
        write_reg(CFG_PENALTY, 32'd0);
        for (int i = 0; i < 66; i++)
            send_element($urandom, $urandom, i == 65);
        drain_results();

        // random phases
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(CFG_PENALTY, (ph == 1) ? 32'hFFFF_FFFF : $urandom_range(0, 32'h0004_0000));
            write_reg(CFG_STEP, (ph == 2) ? 32'hFFFF_FFFF : $urandom_range(0, 32'h0002_0000));
            write_reg(CFG_WEIGHTED, 32'(ph[0]));
            write_reg(CFG_TRUNCATE, 32'(ph[1] | ph[2]));
            write_reg(CFG_DROP_FRAC, (ph == 7) ? 32'h01FF_FFFF : $urandom_range(0, 25'h100_0000));
            write_reg(CFG_TOLERANCE, (ph == 5) ? 32'hFFFF_FFFF : $urandom_range(0, 32'h0002_0000));
            for (int v = 0; v < 3; v++)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 64) : $urandom_range(1, 12);
                for (int e = 0; e < len; e++)
                begin
                    xb = $urandom;
                    if ($urandom_range(0, 2) == 0) xb = $signed(xb) >>> $urandom_range(8, 20);
                    if ($urandom_range(0, 5) == 0 && e > 0) xb = mag_q[0];
                    send_element(xb, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h3_0000),
                                 e == len - 1);
                end
            end
            drain_results();
        end
        write_reg(CFG_UNUSED, $urandom);
        write_reg(CFG_TRUNCATE, 32'd0);

        drain_results();
        if (errors == 0)
            $display("soft_threshold_with_truncation_test OK");
        else
            $display("soft_threshold_with_truncation_test NOT OK");
        $finish;
    end
endmodule
